// File: design/gmre_pkg.sv
// Shared constants, types and helper functions of the grid MRF labeling energy unit.
package gmre_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int ENERGY_BITS = 16;

   localparam int PAIR_TERMS = 4;
   localparam int PAIR_E10   = 1;
   localparam int PAIR_E01   = 2;
   localparam int PAIR_E11   = 3;

   localparam int SIZE_BITS = 11;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int ACC_BITS  = 48;
   localparam int OUT_BITS  = 18;
   localparam int PROD_BITS = 2 * SIZE_BITS;
   localparam int STEP_BITS = $clog2(ACC_BITS);
   localparam int LINE_BITS = 1 + PAIR_TERMS * ENERGY_BITS;

   // register indexes of the configuration port
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic signed [ENERGY_BITS-1:0] energy_type;
   typedef logic [1:0]                    pair_idx_type;

   // controller to datapath
   typedef struct packed {
      logic accept;    // latch request, read line store
      logic exec;      // accumulate, write back, advance counters
      logic div_step;  // one restoring division step
      logic out_load;  // load the result register
   } gmre_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_pixel;
   } gmre_status_type;

   // pair index: first + 2*second
   function automatic pair_idx_type pair_index(input logic first, input logic second);
      pair_idx_type idx;
      idx = '0;
      if (first && second)
         idx = pair_idx_type'(PAIR_E11);
      else if (first)
         idx = pair_idx_type'(PAIR_E10);
      else if (second)
         idx = pair_idx_type'(PAIR_E01);
      return idx;
   endfunction

   // sign extend one energy to accumulator width
   function automatic logic [ACC_BITS-1:0] sext_acc(input energy_type e);
      return {{(ACC_BITS-ENERGY_BITS){e[ENERGY_BITS-1]}}, e};
   endfunction

endpackage

// File: design/gmre_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module gmre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/gmre_datapath.sv
// Datapath: size registers, line store, energy accumulator, divider and result register.
module gmre_datapath
   import gmre_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  gmre_cmd_type        cmd,
   output gmre_status_type     status,
   input  logic                req_pixel_label,
   input  energy_type          req_unary_background,
   input  energy_type          req_unary_foreground,
   input  energy_type          req_down_e00,
   input  energy_type          req_down_e10,
   input  energy_type          req_down_e01,
   input  energy_type          req_down_e11,
   input  energy_type          req_right_e00,
   input  energy_type          req_right_e10,
   input  energy_type          req_right_e01,
   input  energy_type          req_right_e11,
   input  logic                csr_write_en,
   input  logic                csr_index,
   input  logic [SIZE_BITS-1:0] csr_data,
   output logic signed [OUT_BITS-1:0] rsp_mean_energy
);

   // configuration
   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [SIZE_BITS-1:0] w_eff, h_eff;

   // counters
   logic [COL_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0] row_ff;
   logic                last_col, last_row;

   // latched request
   logic       lab_ff;
   energy_type unary_ff;
   energy_type down_ff  [PAIR_TERMS];
   energy_type right_ff [PAIR_TERMS];

   // left neighbor
   logic       left_lab_ff;
   energy_type left_e_ff [PAIR_TERMS];

   // line store
   logic [LINE_BITS-1:0] line_wr_data, line_rd_data;
   logic                 upper_lab;
   energy_type           upper_e [PAIR_TERMS];

   // accumulation
   logic [ACC_BITS-1:0] acc_ff, sum_next, sum_mag;
   energy_type          vert_e, horiz_e;

   // divider
   logic [ACC_BITS-1:0]  quot_ff;
   logic [PROD_BITS-1:0] rem_ff, div_d_ff;
   logic [PROD_BITS:0]   rem_sh;
   logic                 neg_ff;
   logic signed [OUT_BITS-1:0] mean_sat, mean_ff;

   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                       input logic [SIZE_BITS-1:0] mx);
      logic [SIZE_BITS-1:0] r;
      r = v;
      if (v == '0)
         r = SIZE_BITS'(1);
      else if (v > mx)
         r = mx;
      return r;
   endfunction

   assign w_eff = clamp_size(width_ff, SIZE_BITS'(MAX_WIDTH));
   assign h_eff = clamp_size(height_ff, SIZE_BITS'(MAX_HEIGHT));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_BITS'(MAX_WIDTH);
         height_ff <= SIZE_BITS'(MAX_HEIGHT);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   // end of row / end of image
   assign last_col = (SIZE_BITS'(col_ff) + SIZE_BITS'(1)) >= w_eff;
   assign last_row = (SIZE_BITS'(row_ff) + SIZE_BITS'(1)) >= h_eff;
   assign status.last_pixel = last_col && last_row;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         lab_ff      <= req_pixel_label;
         unary_ff    <= req_pixel_label ? req_unary_foreground : req_unary_background;
         down_ff[0]  <= req_down_e00;
         down_ff[1]  <= req_down_e10;
         down_ff[2]  <= req_down_e01;
         down_ff[3]  <= req_down_e11;
         right_ff[0] <= req_right_e00;
         right_ff[1] <= req_right_e10;
         right_ff[2] <= req_right_e01;
         right_ff[3] <= req_right_e11;
      end
   end

   // line store: label of the pixel above and its four down energies
   assign line_wr_data = {lab_ff, down_ff[3], down_ff[2], down_ff[1], down_ff[0]};

   gmre_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.exec),
      .wr_addr (col_ff),
      .wr_data (line_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (col_ff),
      .rd_data (line_rd_data)
   );

   assign upper_lab = line_rd_data[LINE_BITS-1];
   always_comb begin
      for (int k = 0; k < PAIR_TERMS; k++) begin
         upper_e[k] = line_rd_data[k*ENERGY_BITS +: ENERGY_BITS];
      end
   end

   // pair terms; none on the first row or first column
   assign vert_e  = (row_ff != '0) ? upper_e[pair_index(upper_lab, lab_ff)] : '0;
   assign horiz_e = (col_ff != '0) ? left_e_ff[pair_index(left_lab_ff, lab_ff)] : '0;

   assign sum_next = acc_ff + sext_acc(unary_ff) + sext_acc(vert_e) + sext_acc(horiz_e);
   assign sum_mag  = sum_next[ACC_BITS-1] ? (ACC_BITS'(0) - sum_next) : sum_next;

   // accumulator and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.exec) begin
         acc_ff <= status.last_pixel ? '0 : sum_next;
         if (!last_col) begin
            col_ff <= col_ff + COL_BITS'(1);
         end else begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : (row_ff + ROW_BITS'(1));
         end
      end
   end

   // left neighbor
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         left_lab_ff <= lab_ff;
         for (int k = 0; k < PAIR_TERMS; k++) begin
            left_e_ff[k] <= right_ff[k];
         end
      end
   end

   // restoring divider on the magnitude, one quotient bit per step
   assign rem_sh = {rem_ff, quot_ff[ACC_BITS-1]};

   always_ff @(posedge clock) begin
      if (cmd.exec && status.last_pixel) begin
         quot_ff  <= sum_mag;
         neg_ff   <= sum_next[ACC_BITS-1];
         rem_ff   <= '0;
         div_d_ff <= PROD_BITS'(w_eff) * PROD_BITS'(h_eff);
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, div_d_ff}) begin
            rem_ff  <= PROD_BITS'(rem_sh - {1'b0, div_d_ff});
            quot_ff <= {quot_ff[ACC_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[PROD_BITS-1:0];
            quot_ff <= {quot_ff[ACC_BITS-2:0], 1'b0};
         end
      end
   end

   // sign and saturation to the output range
   always_comb begin
      if (neg_ff) begin
         if (quot_ff > ACC_BITS'(2**(OUT_BITS-1)))
            mean_sat = {1'b1, {(OUT_BITS-1){1'b0}}};
         else
            mean_sat = OUT_BITS'(0) - quot_ff[OUT_BITS-1:0];
      end else begin
         if (quot_ff > ACC_BITS'(2**(OUT_BITS-1) - 1))
            mean_sat = {1'b0, {(OUT_BITS-1){1'b1}}};
         else
            mean_sat = quot_ff[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         mean_ff <= mean_sat;
      end
   end

   assign rsp_mean_energy = mean_ff;

endmodule

// File: design/gmre_ctrl.sv
// Controller: sequences each pixel, the end-of-image division and the result handshake.
module gmre_ctrl
   import gmre_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  gmre_status_type status,
   output gmre_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DIVIDE,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_ok;

   assign out_ok = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            step_in  = '0;
            state_in = status.last_pixel ? S_DIVIDE : S_IDLE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(ACC_BITS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_ok) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/grid_mrf_labeling_energy_unit.sv
// Top level of the grid MRF labeling energy unit.
// Pixels arrive in raster order; each request passes through S_IDLE, which latches it and
// reads the line-store entry of the pixel above, and S_EXEC, which adds the unary and pair
// terms and writes the entry back, so no new pixel is taken before the last one is through.
// At the last pixel of an image the 48-bit sum is divided by width*height in a restoring
// divider that produces one quotient bit per cycle, then the result register is loaded once
// the previous mean has been taken; no request is accepted during the division and the load.
// A finished mean waits in its output register while the next image streams in. Sizes must
// be written on the csr port only while idle; the block itself does not enforce this. A size
// of 0 acts as 1 and one above 1024 acts as 1024.
module grid_mrf_labeling_energy_unit
   import gmre_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_pixel_label,
   input  logic signed [ENERGY_BITS-1:0] req_unary_background,
   input  logic signed [ENERGY_BITS-1:0] req_unary_foreground,
   input  logic signed [ENERGY_BITS-1:0] req_down_e00,
   input  logic signed [ENERGY_BITS-1:0] req_down_e10,
   input  logic signed [ENERGY_BITS-1:0] req_down_e01,
   input  logic signed [ENERGY_BITS-1:0] req_down_e11,
   input  logic signed [ENERGY_BITS-1:0] req_right_e00,
   input  logic signed [ENERGY_BITS-1:0] req_right_e10,
   input  logic signed [ENERGY_BITS-1:0] req_right_e01,
   input  logic signed [ENERGY_BITS-1:0] req_right_e11,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_BITS-1:0] rsp_mean_energy,
   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic [SIZE_BITS-1:0]       csr_data
);

   gmre_cmd_type    cmd;
   gmre_status_type status;

   gmre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gmre_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_pixel_label      (req_pixel_label),
      .req_unary_background (req_unary_background),
      .req_unary_foreground (req_unary_foreground),
      .req_down_e00         (req_down_e00),
      .req_down_e10         (req_down_e10),
      .req_down_e01         (req_down_e01),
      .req_down_e11         (req_down_e11),
      .req_right_e00        (req_right_e00),
      .req_right_e10        (req_right_e10),
      .req_right_e01        (req_right_e01),
      .req_right_e11        (req_right_e11),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_mean_energy      (rsp_mean_energy)
   );

endmodule

// File: design/gmre_checker.sv
// Port-level checks of the grid MRF labeling energy unit, bound to the top level.
module gmre_checker
   import gmre_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [OUT_BITS-1:0] rsp_mean_energy
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_energy))
      else $error("stalled result changed or dropped");

   // a pixel passes through S_IDLE and S_EXEC: no request is taken in the cycle after one is taken
   a_pixel_two_cycles: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on back-to-back cycles");

   // a new result comes out of the division, when no request is taken
   a_rsp_after_divide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while requests were being taken");

   // reset leaves the block ready with no result pending
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind grid_mrf_labeling_energy_unit gmre_checker u_checker (.*);
